// ===== hw/rtl/bwa_pkg.sv =====
`timescale 1ns / 1ps

package bwa_pkg;

  localparam int unsigned SumW = 16;
  localparam int unsigned LenW = 17;

  localparam logic [SumW-1:0] ADLER_MOD = 16'd65521;
  localparam logic [LenW-1:0] BLOCK_SIZE = 17'd65536;
  localparam logic [LenW-1:0] MAX_FIRST_LEN = 17'd65536;

  // Running sums of the open block and of the message so far.
  typedef struct packed {
    logic [SumW-1:0] blk_lo;
    logic [SumW-1:0] blk_hi;
    logic [LenW-1:0] cnt;
    logic            first;
    logic [SumW-1:0] msg_lo;
    logic [SumW-1:0] msg_hi;
  } bwa_state_t;

  localparam bwa_state_t STATE_RESET = '{
    blk_lo: 16'd1,
    blk_hi: 16'd0,
    cnt:    17'd0,
    first:  1'b1,
    msg_lo: 16'd1,
    msg_hi: 16'd0
  };

  typedef struct packed {
    logic [31:0]     block_checksum;
    logic [31:0]     whole_checksum;
    logic [LenW-1:0] block_length;
    logic            last_block;
  } bwa_result_t;

  // a + b mod 65521, both operands already reduced
  function automatic logic [SumW-1:0] mod_add(input logic [SumW-1:0] a,
                                               input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, ADLER_MOD}) begin
      s = s - {1'b0, ADLER_MOD};
    end
    return s[SumW-1:0];
  endfunction

endpackage

// ===== hw/rtl/bwa_step.sv =====
`timescale 1ns / 1ps

module bwa_step
  import bwa_pkg::*;
(
  input  bwa_state_t      cur,
  input  logic [LenW-1:0] first_limit,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output bwa_state_t      nxt,
  output logic            emit,
  output bwa_result_t     res
);

  logic [SumW-1:0] blk_lo_upd;
  logic [SumW-1:0] blk_hi_upd;
  logic [SumW-1:0] msg_lo_upd;
  logic [SumW-1:0] msg_hi_upd;
  logic [LenW-1:0] cnt_upd;
  logic [LenW-1:0] limit;

  // The whole-message value is kept as a plain running Adler-32; with fully
  // reduced sums this is exactly what the combine rule yields at block ends.
  assign blk_lo_upd = mod_add(cur.blk_lo, {8'd0, data_byte});
  assign blk_hi_upd = mod_add(cur.blk_hi, blk_lo_upd);
  assign msg_lo_upd = mod_add(cur.msg_lo, {8'd0, data_byte});
  assign msg_hi_upd = mod_add(cur.msg_hi, msg_lo_upd);
  assign cnt_upd    = cur.cnt + 17'd1;

  assign limit = cur.first ? first_limit : BLOCK_SIZE;
  assign emit  = last_byte || (cnt_upd >= limit);

  always_comb begin
    res.block_checksum = {blk_hi_upd, blk_lo_upd};
    res.whole_checksum = {msg_hi_upd, msg_lo_upd};
    res.block_length   = cnt_upd;
    res.last_block     = last_byte;
  end

  always_comb begin
    nxt = '{
      blk_lo: blk_lo_upd,
      blk_hi: blk_hi_upd,
      cnt:    cnt_upd,
      first:  cur.first,
      msg_lo: msg_lo_upd,
      msg_hi: msg_hi_upd
    };
    if (emit) begin
      nxt.blk_lo = STATE_RESET.blk_lo;
      nxt.blk_hi = STATE_RESET.blk_hi;
      nxt.cnt    = STATE_RESET.cnt;
      nxt.first  = 1'b0;
      if (last_byte) begin
        nxt = STATE_RESET;
      end
    end
  end

endmodule

// ===== hw/rtl/blockwise_adler32_checksummer_core.sv =====
`timescale 1ns / 1ps

// Blockwise Adler-32 checksummer.
// Input channel (in_valid / in_stall) carries one message byte per
// transaction, with in_last_byte marking the end of a message. The message
// is cut into blocks: the first of cfg_wr_data bytes (0 reads as 1, above
// 65536 reads as 65536), later ones of 65536 bytes, the last possibly short.
// Each finished block produces one transaction on the result channel
// (out_valid / out_stall) with the block's Adler-32, the Adler-32 of the
// message through that block, the block length and a last-block flag.
// One byte per cycle while in_stall is low. A block's result is registered in
// the output register, or in the skid entry while that is held; the per-byte
// update is two mod-65521 adds for the block and two for the message.
// When the receiver stalls, results park in the output register and a single
// skid entry; bytes that close no block are still taken, and in_stall rises
// only once the skid entry is occupied.
// Reset (rst_n low, synchronous) empties both result registers, restores the
// first block length to 65536 and starts a new message.
// Write cfg_wr_data with cfg_wr_en only while the block is idle.

module blockwise_adler32_checksummer_core
  import bwa_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [LenW-1:0] cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_block_checksum,
  output logic [31:0]     out_whole_checksum,
  output logic [LenW-1:0] out_block_length,
  output logic            out_last_block
);

  logic [LenW-1:0] first_limit_r;
  bwa_state_t      state_r;
  bwa_state_t      state_nxt;
  logic            emit;
  bwa_result_t     step_res;
  bwa_result_t     out_r;
  bwa_result_t     skid_r;
  logic            out_valid_r;
  logic            skid_valid_r;
  logic            in_take;
  logic            out_take;

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  bwa_step u_step (
    .cur         (state_r),
    .first_limit (first_limit_r),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .nxt         (state_nxt),
    .emit        (emit),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_limit_r <= MAX_FIRST_LEN;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        first_limit_r <= 17'd1;
      end else if (cfg_wr_data > MAX_FIRST_LEN) begin
        first_limit_r <= MAX_FIRST_LEN;
      end else begin
        first_limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Output register plus one skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_r       <= step_res;
        out_valid_r <= in_take && emit;
      end
    end else if (in_take && emit) begin
      skid_r       <= step_res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_block_checksum = out_r.block_checksum;
  assign out_whole_checksum = out_r.whole_checksum;
  assign out_block_length   = out_r.block_length;
  assign out_last_block     = out_r.last_block;

endmodule

// ===== hw/rtl/bwa_checker.sv =====
`timescale 1ns / 1ps

module bwa_checker
  import bwa_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [31:0]     out_block_checksum,
  input logic [31:0]     out_whole_checksum,
  input logic [LenW-1:0] out_block_length
);

  // Nothing is pending right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result must not vanish.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // Input backpressure only when results are backed up.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  // All sums reduced mod 65521 and lengths within block range.
  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_block_checksum[15:0] < ADLER_MOD) &&
                  (out_block_checksum[31:16] < ADLER_MOD) &&
                  (out_whole_checksum[15:0] < ADLER_MOD) &&
                  (out_whole_checksum[31:16] < ADLER_MOD) &&
                  (out_block_length != '0) && (out_block_length <= BLOCK_SIZE))
    else $error("result sums or length out of range");

endmodule

bind blockwise_adler32_checksummer_core bwa_checker u_bwa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_block_checksum (out_block_checksum),
  .out_whole_checksum (out_whole_checksum),
  .out_block_length   (out_block_length)
);
